### sv/bresenham_line_rasterizer_top_macros.svh
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - assertion macros
// Implication and next-cycle implication checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define BRL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define BRL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/brl_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - shared package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package brl_pkg;

   localparam int CFG_W               = 13;
   localparam int IDX_W               = 25;
   localparam int COLOR_W             = 32;
   localparam int RES_W               = 1 + IDX_W + COLOR_W + 1;
   localparam int COORD_BITS_DEFAULT  = 14;
   localparam int CMD_DEPTH_DEFAULT   = 4;
   localparam int RSP_DEPTH_DEFAULT   = 4;

   localparam logic [CFG_W-1:0] VIEW_WIDTH_RESET  = 13'd1024;
   localparam logic [CFG_W-1:0] VIEW_HEIGHT_RESET = 13'd768;
   localparam logic [CFG_W-1:0] ROW_PITCH_RESET   = 13'd1024;

   typedef enum logic [1:0] {
      CSR_VIEW_WIDTH  = 2'd0,
      CSR_VIEW_HEIGHT = 2'd1,
      CSR_ROW_PITCH   = 2'd2
   } brl_csr_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_STEP = 1'b1
   } brl_kind_type;

   typedef struct packed {
      logic [CFG_W-1:0] view_width;
      logic [CFG_W-1:0] view_height;
      logic [CFG_W-1:0] row_pitch_words;
   } brl_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } brl_fifo_status_type;

endpackage

### sv/bresenham_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - top level
// Line stepping with screen clipping and framebuffer word address output.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req_      in         push / full          kind, start/end point, line colour
// rsp_      out        empty / pop          write enable, pixel index, colour, done
// csr_      in         valid / ready        register index, write data
//
// One request per cycle sustained; requests stall only on a full command queue.
// A step reaches the result ports by way of the command
// queue, the stepper, then the pitch multiply with the address add into the result queue.
// Reset is synchronous; no clearing pass. The stepper holds steps
// while the result queue lacks room; loads still drain and give no result.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT,
   parameter int CMD_DEPTH  = brl_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH  = brl_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_kind,
   input  logic signed [COORD_BITS-1:0]       req_start_x,
   input  logic signed [COORD_BITS-1:0]       req_start_y,
   input  logic signed [COORD_BITS-1:0]       req_end_x,
   input  logic signed [COORD_BITS-1:0]       req_end_y,
   input  logic        [brl_pkg::COLOR_W-1:0] req_line_color,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_write_enable,
   output logic        [brl_pkg::IDX_W-1:0]   rsp_pixel_index,
   output logic        [brl_pkg::COLOR_W-1:0] rsp_pixel_color,
   output logic                               rsp_line_done,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic        [1:0]                  csr_index,
   input  logic        [brl_pkg::CFG_W-1:0]   csr_data
);

   // kind, four points, |dx|, -|dy|, two step signs, error term, colour
   localparam int CMD_W = 1 + 4 * COORD_BITS + COORD_BITS + (COORD_BITS + 1) + 2
                        + (COORD_BITS + 3) + brl_pkg::COLOR_W;

   brl_pkg::brl_cfg_type         cfg_ff, cfg_in;
   brl_pkg::brl_fifo_status_type cmd_status, rsp_status;
   logic                         cmd_push, cmd_pop, res_push, rsp_take;
   logic [CMD_W-1:0]             cmd_wdata, cmd_rdata;
   logic [brl_pkg::RES_W-1:0]    res_data, rsp_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (brl_pkg::brl_csr_type'(csr_index))
            brl_pkg::CSR_VIEW_WIDTH:  cfg_in.view_width      = csr_data;
            brl_pkg::CSR_VIEW_HEIGHT: cfg_in.view_height     = csr_data;
            brl_pkg::CSR_ROW_PITCH:   cfg_in.row_pitch_words = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_width      <= brl_pkg::VIEW_WIDTH_RESET;
         cfg_ff.view_height     <= brl_pkg::VIEW_HEIGHT_RESET;
         cfg_ff.row_pitch_words <= brl_pkg::ROW_PITCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   brl_front #(
      .COORD_BITS (COORD_BITS),
      .CMD_W      (CMD_W)
   ) u_front (
      .req_push       (req_push),
      .full           (req_full),
      .req_kind       (req_kind),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_line_color (req_line_color),
      .cmd_status     (cmd_status),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_wdata)
   );

   brl_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .status    (cmd_status)
   );

   brl_back #(
      .COORD_BITS (COORD_BITS),
      .CMD_W      (CMD_W),
      .RSP_DEPTH  (RSP_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_status (cmd_status),
      .cmd_data   (cmd_rdata),
      .cmd_pop    (cmd_pop),
      .rsp_take   (rsp_take),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   assign rsp_take = rsp_pop & ~rsp_status.empty;

   brl_fifo #(
      .WIDTH (brl_pkg::RES_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .status    (rsp_status)
   );

   assign rsp_empty = rsp_status.empty;
   assign {rsp_write_enable, rsp_pixel_index, rsp_pixel_color, rsp_line_done} = rsp_data;

endmodule

### sv/brl_fifo.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - small synchronous queue
// Register-array queue with wrapping pointers and an occupancy count.
// ----------------------------------------------------------------------------
module brl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output brl_pkg::brl_fifo_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_data     = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/brl_front.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - front end
// Accepts requests, works out deltas, step signs and the initial error term
// for loads, and queues the classified command for the stepper.
// ----------------------------------------------------------------------------
module brl_front #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT,
   parameter int CMD_W      = 1
) (
   input  logic                                 req_push,
   output logic                                 full,
   input  logic                                 req_kind,
   input  logic signed [COORD_BITS-1:0]         req_start_x,
   input  logic signed [COORD_BITS-1:0]         req_start_y,
   input  logic signed [COORD_BITS-1:0]         req_end_x,
   input  logic signed [COORD_BITS-1:0]         req_end_y,
   input  logic        [brl_pkg::COLOR_W-1:0]   req_line_color,
   input  brl_pkg::brl_fifo_status_type         cmd_status,
   output logic                                 cmd_push,
   output logic        [CMD_W-1:0]              cmd_data
);

   localparam int C = COORD_BITS;

   logic signed [C:0]   dx, dy;
   logic        [C:0]   abs_dx_full, abs_dy_full;
   logic        [C-1:0] abs_dx;
   logic signed [C:0]   neg_abs_dy;
   logic signed [C+2:0] error_init;
   logic                step_x_neg, step_y_neg;

   always_comb begin
      dx          = $signed({req_end_x[C-1], req_end_x})
                  - $signed({req_start_x[C-1], req_start_x});
      dy          = $signed({req_end_y[C-1], req_end_y})
                  - $signed({req_start_y[C-1], req_start_y});
      abs_dx_full = dx[C] ? -dx : dx;
      abs_dy_full = dy[C] ? -dy : dy;
      abs_dx      = abs_dx_full[C-1:0];
      neg_abs_dy  = -$signed({1'b0, abs_dy_full[C-1:0]});
      error_init  = $signed({3'b000, abs_dx}) + $signed({{2{neg_abs_dy[C]}}, neg_abs_dy});
      step_x_neg  = !(req_start_x < req_end_x);
      step_y_neg  = !(req_start_y < req_end_y);
   end

   assign full     = cmd_status.full;
   assign cmd_push = req_push & ~cmd_status.full;
   assign cmd_data = {req_kind, req_start_x, req_start_y, req_end_x, req_end_y,
                      abs_dx, neg_abs_dy, step_x_neg, step_y_neg, error_init,
                      req_line_color};

endmodule

### sv/brl_back.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - stepper and address pipeline
// Holds the line state, emits one point per step command, advances the error
// term, then forms y * pitch + x with a registered pitch multiply and the address add.
// ----------------------------------------------------------------------------
module brl_back #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT,
   parameter int CMD_W      = 1,
   parameter int RSP_DEPTH  = brl_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  brl_pkg::brl_cfg_type           cfg,
   input  brl_pkg::brl_fifo_status_type   cmd_status,
   input  logic [CMD_W-1:0]               cmd_data,
   output logic                           cmd_pop,
   input  logic                           rsp_take,
   output logic                           res_push,
   output logic [brl_pkg::RES_W-1:0]      res_data
);

   localparam int C      = COORD_BITS;
   localparam int CFG_W  = brl_pkg::CFG_W;
   localparam int IDX_W  = brl_pkg::IDX_W;
   localparam int COL_W  = brl_pkg::COLOR_W;
   localparam int CMP_W  = (C > CFG_W) ? C : CFG_W;
   localparam int PROD_W = C + CFG_W;
   localparam int SUM_W  = (PROD_W + 1 > IDX_W) ? PROD_W + 1 : IDX_W;
   localparam int RW     = $clog2(RSP_DEPTH + 1);

   // command fields
   logic                c_kind;
   logic signed [C-1:0] c_x0, c_y0, c_x1, c_y1;
   logic        [C-1:0] c_abs_dx;
   logic signed [C:0]   c_neg_abs_dy;
   logic                c_sxn, c_syn;
   logic signed [C+2:0] c_err;
   logic [COL_W-1:0]    c_color;

   assign {c_kind, c_x0, c_y0, c_x1, c_y1, c_abs_dx, c_neg_abs_dy, c_sxn, c_syn,
           c_err, c_color} = cmd_data;

   // line state
   logic signed [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [C-1:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic        [C-1:0] abs_dx_ff, abs_dx_in;
   logic signed [C:0]   neg_abs_dy_ff, neg_abs_dy_in;
   logic                step_x_neg_ff, step_x_neg_in, step_y_neg_ff, step_y_neg_in;
   logic signed [C+2:0] error_term_ff, error_term_in;
   logic [COL_W-1:0]    held_color_ff, held_color_in;
   logic                active_ff, active_in;

   // pipeline
   logic                s1_valid_ff, s1_valid_in, s1_we_ff, s1_we_in;
   logic                s1_done_ff, s1_done_in;
   logic [COL_W-1:0]    s1_color_ff, s1_color_in;
   logic [C-1:0]        s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic                s2_valid_ff, s2_we_ff, s2_done_ff;
   logic [COL_W-1:0]    s2_color_ff;
   logic [C-1:0]        s2_x_ff;
   logic [PROD_W-1:0]   s2_prod_ff;
   logic [RW-1:0]       reserved_ff, reserved_in;

   logic                has_room, step_go, on_screen, done_pt, adv_x, adv_y;
   logic signed [C+3:0] e2;
   logic [C-1:0]        x_inc, y_inc;
   logic [SUM_W-1:0]    addr_sum;

   assign has_room = (reserved_ff < RW'(RSP_DEPTH));
   assign cmd_pop  = ~cmd_status.empty
                   & ((c_kind == brl_pkg::KIND_LOAD) | has_room);
   assign step_go  = cmd_pop & (c_kind == brl_pkg::KIND_STEP);

   always_comb begin
      on_screen = !cur_x_ff[C-1] && !cur_y_ff[C-1]
                && (CMP_W'($unsigned(cur_x_ff)) < CMP_W'(cfg.view_width))
                && (CMP_W'($unsigned(cur_y_ff)) < CMP_W'(cfg.view_height));
      done_pt   = (cur_x_ff == target_x_ff) && (cur_y_ff == target_y_ff);
      e2        = $signed({error_term_ff, 1'b0});
      adv_x     = e2 >= $signed({{3{neg_abs_dy_ff[C]}}, neg_abs_dy_ff});
      adv_y     = e2 <= $signed({4'b0000, abs_dx_ff});
      x_inc     = step_x_neg_ff ? {C{1'b1}} : C'(1);
      y_inc     = step_y_neg_ff ? {C{1'b1}} : C'(1);

      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      abs_dx_in     = abs_dx_ff;
      neg_abs_dy_in = neg_abs_dy_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_term_in = error_term_ff;
      held_color_in = held_color_ff;
      active_in     = active_ff;
      s1_valid_in   = step_go;
      s1_we_in      = 1'b0;
      s1_done_in    = 1'b0;
      s1_color_in   = '0;
      s1_x_in       = cur_x_ff;
      s1_y_in       = cur_y_ff;

      if (cmd_pop) begin
         case (brl_pkg::brl_kind_type'(c_kind))
            brl_pkg::KIND_LOAD: begin
               cur_x_in      = c_x0;
               cur_y_in      = c_y0;
               target_x_in   = c_x1;
               target_y_in   = c_y1;
               abs_dx_in     = c_abs_dx;
               neg_abs_dy_in = c_neg_abs_dy;
               step_x_neg_in = c_sxn;
               step_y_neg_in = c_syn;
               error_term_in = c_err;
               held_color_in = c_color;
               active_in     = 1'b1;
            end
            brl_pkg::KIND_STEP: begin
               if (active_ff) begin
                  s1_we_in    = on_screen;
                  s1_done_in  = done_pt;
                  s1_color_in = held_color_ff;
                  if (done_pt) begin
                     active_in = 1'b0;
                  end else begin
                     error_term_in = error_term_ff
                        + (adv_x ? {{2{neg_abs_dy_ff[C]}}, neg_abs_dy_ff} : '0)
                        + (adv_y ? {3'b000, abs_dx_ff} : '0);
                     if (adv_x) begin
                        cur_x_in = cur_x_ff + x_inc;
                     end
                     if (adv_y) begin
                        cur_y_in = cur_y_ff + y_inc;
                     end
                  end
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end

      reserved_in = reserved_ff;
      if (step_go && !rsp_take) begin
         reserved_in = reserved_ff + RW'(1);
      end else if (!step_go && rsp_take) begin
         reserved_in = reserved_ff - RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         reserved_ff <= '0;
      end else begin
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         reserved_ff <= reserved_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      target_x_ff   <= target_x_in;
      target_y_ff   <= target_y_in;
      abs_dx_ff     <= abs_dx_in;
      neg_abs_dy_ff <= neg_abs_dy_in;
      step_x_neg_ff <= step_x_neg_in;
      step_y_neg_ff <= step_y_neg_in;
      error_term_ff <= error_term_in;
      held_color_ff <= held_color_in;
      s1_we_ff      <= s1_we_in;
      s1_done_ff    <= s1_done_in;
      s1_color_ff   <= s1_color_in;
      s1_x_ff       <= s1_x_in;
      s1_y_ff       <= s1_y_in;
      s2_we_ff      <= s1_we_ff;
      s2_done_ff    <= s1_done_ff;
      s2_color_ff   <= s1_color_ff;
      s2_x_ff       <= s1_x_ff;
      s2_prod_ff    <= PROD_W'(s1_y_ff) * PROD_W'(cfg.row_pitch_words);
   end

   assign addr_sum = SUM_W'(s2_prod_ff) + SUM_W'(s2_x_ff);
   assign res_push = s2_valid_ff;
   assign res_data = {s2_we_ff, s2_we_ff ? addr_sum[IDX_W-1:0] : {IDX_W{1'b0}},
                      s2_color_ff, s2_done_ff};

endmodule

### sv/brl_port_checker.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - port checker
// Watches the top-level ports for reset, clipping and result-hold behaviour.
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_top_macros.svh"

module brl_port_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic                               rsp_write_enable,
   input logic        [brl_pkg::IDX_W-1:0]   rsp_pixel_index,
   input logic        [brl_pkg::COLOR_W-1:0] rsp_pixel_color,
   input logic                               rsp_line_done
);

`BRL_ASSERT_IMPL(a_reset_clears_queues, $past(reset), rsp_empty && !req_full, "queues not clear after reset")
`BRL_ASSERT_IMPL(a_clipped_index_zero, !rsp_empty && !rsp_write_enable, rsp_pixel_index == '0, "clipped point with nonzero index")
`BRL_ASSERT_NEXT(a_stalled_result_holds, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_pixel_index) && $stable(rsp_pixel_color) && $stable(rsp_line_done), "stalled result changed")

endmodule

bind bresenham_line_rasterizer_top brl_port_checker u_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_write_enable (rsp_write_enable),
   .rsp_pixel_index  (rsp_pixel_index),
   .rsp_pixel_color  (rsp_pixel_color),
   .rsp_line_done    (rsp_line_done)
);
